// ===== sv/pdp8_pkg.sv =====
// Package for the PDP-8 instruction executor: shared types, opcodes and constants.
// Used by the controller, datapath and top level through scoped names.
package pdp8_pkg;

  localparam int MEM_WORDS_DEF = 4096;
  localparam int CYC_BITS_DEF  = 40;
  localparam int WORD_BITS     = 12;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_SETPC = 2'd1,
    ACT_EXEC = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    OP_AND = 3'd0, OP_TAD = 3'd1, OP_ISZ = 3'd2, OP_DCA = 3'd3,
    OP_JMS = 3'd4, OP_JMP = 3'd5, OP_IOT = 3'd6, OP_OPR = 3'd7
  } opcode_t;

  localparam logic [5:0] DEV_KBD = 6'd3;
  localparam logic [5:0] DEV_PRT = 6'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_FETCH, ST_DECODE, ST_INDIR, ST_OPER, ST_EXEC, ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take_in;    // capture the request
    logic       clr_write;  // write zero at the clear address
    logic       load_write; // write the load word
    logic       set_pc;
    logic       rd_pc;      // memory read at program counter
    logic       rd_ea;      // memory read at effective address
    logic       lat_ir;     // latch instruction word, form address
    logic       lat_ind;    // latch indirect pointer as address
    logic       execute;    // execute with operand on read data
    logic       finish;     // build the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       clr_last;
    action_t    action;
    logic       halted;
    logic       indirect;
    logic       mem_ref;    // opcode takes a memory address
  } stat_t;

endpackage

// ===== sv/pdp8_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module pdp8_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== sv/pdp8_ctrl.sv =====
// Controller state machine for the PDP-8 executor.
// Depends on pdp8_pkg.
module pdp8_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  pdp8_pkg::stat_t stat,
  output pdp8_pkg::cmd_t  cmd
);
  pdp8_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdp8_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      pdp8_pkg::ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          state_next = pdp8_pkg::ST_IDLE;
        end
      end
      pdp8_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = pdp8_pkg::ST_FETCH;
        end
      end
      pdp8_pkg::ST_FETCH: begin
        unique case (stat.action)
          pdp8_pkg::ACT_LOAD: begin
            cmd.load_write = 1'b1;
            cmd.finish     = 1'b1;
            state_next     = pdp8_pkg::ST_DONE;
          end
          pdp8_pkg::ACT_SETPC: begin
            cmd.set_pc = 1'b1;
            cmd.finish = 1'b1;
            state_next = pdp8_pkg::ST_DONE;
          end
          pdp8_pkg::ACT_EXEC: begin
            if (stat.halted) begin
              cmd.finish = 1'b1;
              state_next = pdp8_pkg::ST_DONE;
            end else begin
              cmd.rd_pc  = 1'b1;
              state_next = pdp8_pkg::ST_DECODE;
            end
          end
          default: begin
            cmd.finish = 1'b1;
            state_next = pdp8_pkg::ST_DONE;
          end
        endcase
      end
      pdp8_pkg::ST_DECODE: begin
        cmd.lat_ir = 1'b1;
        if (stat.mem_ref && stat.indirect) begin
          state_next = pdp8_pkg::ST_INDIR;
        end else if (stat.mem_ref) begin
          state_next = pdp8_pkg::ST_OPER;
        end else begin
          state_next = pdp8_pkg::ST_EXEC;
        end
      end
      pdp8_pkg::ST_INDIR: begin
        cmd.lat_ind = 1'b1;
        state_next  = pdp8_pkg::ST_OPER;
      end
      pdp8_pkg::ST_OPER: begin
        cmd.rd_ea  = 1'b1;
        state_next = pdp8_pkg::ST_EXEC;
      end
      pdp8_pkg::ST_EXEC: begin
        cmd.execute = 1'b1;
        cmd.finish  = 1'b1;
        state_next  = pdp8_pkg::ST_DONE;
      end
      pdp8_pkg::ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = pdp8_pkg::ST_IDLE;
        end
      end
      default: state_next = pdp8_pkg::ST_IDLE;
    endcase
  end
endmodule

// ===== sv/pdp8_dp.sv =====
// Datapath of the PDP-8 executor: architectural registers, memory port and ALU.
// Depends on pdp8_pkg and pdp8_ram.
module pdp8_dp #(
  parameter int MEMORY_WORDS     = pdp8_pkg::MEM_WORDS_DEF,
  parameter int CYCLE_COUNT_BITS = pdp8_pkg::CYC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pdp8_pkg::cmd_t              cmd,
  output pdp8_pkg::stat_t             stat,
  input  logic [1:0]                  action,
  input  logic [11:0]                 load_address,
  input  logic [11:0]                 data_word,
  input  logic [11:0]                 keyboard_word,
  output logic [11:0]                 program_counter,
  output logic [11:0]                 accumulator_value,
  output logic                        link_value,
  output logic                        halted,
  output logic [11:0]                 executed_word,
  output logic                        keyboard_taken,
  output logic                        print_valid,
  output logic [7:0]                  print_char,
  output logic [CYCLE_COUNT_BITS-1:0] elapsed_cycles
);
  localparam int AW = $clog2(MEMORY_WORDS);

  logic [11:0] pc, ac, ir, ea, r_ld, r_data, r_kbd;
  logic        lk, hlt;
  logic [1:0]  r_act;
  logic [CYCLE_COUNT_BITS-1:0] cyc;
  logic [AW-1:0] clr_addr;
  logic        ran;

  // Memory port.
  logic          we;
  logic [AW-1:0] addr;
  logic [11:0]   wdata, rdata;

  pdp8_ram #(.WIDTH(12), .DEPTH(MEMORY_WORDS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic [2:0]  op;
  logic [8:0]  bits;
  logic [11:0] ea_direct;
  assign op   = rdata[11:9];
  assign bits = rdata[8:0];
  assign ea_direct = {(rdata[7] ? pc[11:7] : 5'd0), rdata[6:0]};

  // Execution stage signals.
  logic [2:0]  xop;
  logic [11:0] ac_x, pc_x, wv;
  logic        lk_x, hlt_x, wr_x, tk_x, pv_x;
  logic [1:0]  cost;
  logic [12:0] sum;
  logic [12:0] rv;
  logic        cond;
  logic [11:0] inc;

  assign xop = ir[11:9];

  always_comb begin
    ac_x = ac; lk_x = lk; pc_x = pc + 12'd1; hlt_x = hlt;
    wr_x = 1'b0; wv = '0; tk_x = 1'b0; pv_x = 1'b0;
    cost = 2'd1; sum = '0; rv = '0; cond = 1'b0;
    inc = rdata + 12'd1;
    unique case (pdp8_pkg::opcode_t'(xop))
      pdp8_pkg::OP_AND: begin
        ac_x = ac & rdata;
        cost = ir[8] ? 2'd3 : 2'd2;
      end
      pdp8_pkg::OP_TAD: begin
        sum  = {1'b0, ac} + {1'b0, rdata};
        ac_x = sum[11:0];
        lk_x = lk ^ sum[12];
        cost = ir[8] ? 2'd3 : 2'd2;
      end
      pdp8_pkg::OP_ISZ: begin
        wr_x = 1'b1; wv = inc;
        if (inc == 12'd0) pc_x = pc + 12'd2;
        cost = 2'd2;
      end
      pdp8_pkg::OP_DCA: begin
        wr_x = 1'b1; wv = ac; ac_x = '0;
        cost = ir[8] ? 2'd3 : 2'd2;
      end
      pdp8_pkg::OP_JMS: begin
        wr_x = 1'b1; wv = pc + 12'd1; pc_x = ea + 12'd1;
        cost = ir[8] ? 2'd3 : 2'd2;
      end
      pdp8_pkg::OP_JMP: begin
        pc_x = ea;
        cost = ir[8] ? 2'd2 : 2'd1;
      end
      pdp8_pkg::OP_IOT: begin
        if (ir[8:3] == pdp8_pkg::DEV_KBD) begin
          ac_x = r_kbd; tk_x = 1'b1;
        end else if (ir[8:3] == pdp8_pkg::DEV_PRT) begin
          pv_x = 1'b1;
        end
      end
      pdp8_pkg::OP_OPR: begin
        if (!ir[8]) begin
          rv = {lk, ac};
          if (ir[7]) rv[11:0] = '0;
          if (ir[6]) rv[12] = 1'b0;
          if (ir[5]) rv[11:0] = ~rv[11:0];
          if (ir[4]) rv[12] = ~rv[12];
          if (ir[0]) begin
            sum = {1'b0, rv[11:0]} + 13'd1;
            rv  = {rv[12] ^ sum[12], sum[11:0]};
          end
          if (ir[3]) begin
            rv = {rv[0], rv[12:1]};
            if (ir[1]) rv = {rv[0], rv[12:1]};
          end
          if (ir[2]) begin
            rv = {rv[11:0], rv[12]};
            if (ir[1]) rv = {rv[11:0], rv[12]};
          end
          ac_x = rv[11:0]; lk_x = rv[12];
        end else begin
          cond = (ir[6] && ac[11]) || (ir[5] && ac == 12'd0) || (ir[4] && lk);
          if (ir[3]) cond = !cond;
          if (cond) pc_x = pc + 12'd2;
          if (ir[7]) ac_x = '0;
          if (ir[1]) hlt_x = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Memory port mux.
  always_comb begin
    we = 1'b0; addr = ea[AW-1:0]; wdata = '0;
    priority if (cmd.clr_write) begin
      we = 1'b1; addr = clr_addr;
    end else if (cmd.load_write) begin
      we = 1'b1; addr = r_ld[AW-1:0]; wdata = r_data;
    end else if (cmd.rd_pc) begin
      addr = pc[AW-1:0];
    end else if (cmd.lat_ir) begin
      addr = ea_direct[AW-1:0];
    end else if (cmd.lat_ind) begin
      addr = rdata[AW-1:0];
    end else if (cmd.rd_ea) begin
      addr = ea[AW-1:0];
    end else if (cmd.execute) begin
      we = wr_x; addr = ea[AW-1:0]; wdata = wv;
    end
  end

  localparam logic [CYCLE_COUNT_BITS-1:0] CYC_MAX = '1;
  logic [CYCLE_COUNT_BITS:0] cyc_sum;
  assign cyc_sum = {1'b0, cyc} + {{(CYCLE_COUNT_BITS - 1){1'b0}}, cost};

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0; ac <= '0; lk <= 1'b0; hlt <= 1'b0; cyc <= '0;
      clr_addr <= '0; ran <= 1'b0; r_act <= '0;
    end else begin
      if (cmd.clr_write) clr_addr <= clr_addr + 1'b1;
      if (cmd.take_in) begin
        r_act <= action; r_ld <= load_address; r_data <= data_word;
        r_kbd <= keyboard_word; ran <= 1'b0;
      end
      if (cmd.set_pc) pc <= r_data;
      if (cmd.lat_ir) begin
        ir <= rdata; ea <= ea_direct; ran <= 1'b1;
      end
      if (cmd.lat_ind) ea <= rdata;
      if (cmd.execute) begin
        ac <= ac_x; lk <= lk_x; pc <= pc_x; hlt <= hlt_x;
        cyc <= cyc_sum[CYCLE_COUNT_BITS] ? CYC_MAX : cyc_sum[CYCLE_COUNT_BITS-1:0];
      end
      if (cmd.finish) begin
        keyboard_taken <= cmd.execute & tk_x;
        print_valid    <= cmd.execute & pv_x;
        print_char     <= (cmd.execute & pv_x) ? ac[7:0] : 8'd0;
        executed_word  <= (cmd.execute & ran) ? ir : 12'd0;
      end
    end
  end

  assign stat.clr_last = (clr_addr == AW'(MEMORY_WORDS - 1));
  assign stat.action   = pdp8_pkg::action_t'(r_act);
  assign stat.halted   = hlt;
  assign stat.indirect = bits[8];
  assign stat.mem_ref  = (op < pdp8_pkg::OP_IOT);

  assign program_counter   = pc;
  assign accumulator_value = ac;
  assign link_value        = lk;
  assign halted            = hlt;
  assign elapsed_cycles    = cyc;
endmodule

// ===== sv/pdp8_instruction_executor_top.sv =====
// Top level of the PDP-8 instruction executor.
// Depends on pdp8_pkg, pdp8_ctrl, pdp8_dp and pdp8_ram.
//
// This block is a 12-bit PDP-8 processor over a 4096-word single-port memory with
// registered read. Each request loads a memory word, sets the program counter,
// fetches and executes one instruction, or, for the unused action code, does
// nothing; exactly one result follows each request. After reset the block sweeps
// the memory to zero, one word per cycle, and takes no request until the sweep
// has written the last word. One request is handled at a time. A load, a program
// counter set, an unused action code or a step while halted reads no memory; an
// IOT or operate step reads and decodes the instruction, then executes it; a direct
// memory reference adds an operand read, an indirect one a pointer read first.
// The single memory port makes fetch, pointer read, operand read and write-back
// dependent accesses in turn. The block returns to idle once the result is taken.
module pdp8_instruction_executor_top #(
  parameter int MEMORY_WORDS     = pdp8_pkg::MEM_WORDS_DEF,
  parameter int CYCLE_COUNT_BITS = pdp8_pkg::CYC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  action,
  input  logic [11:0]                 load_address,
  input  logic [11:0]                 data_word,
  input  logic [11:0]                 keyboard_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [11:0]                 program_counter,
  output logic [11:0]                 accumulator_value,
  output logic                        link_value,
  output logic                        halted,
  output logic [11:0]                 executed_word,
  output logic                        keyboard_taken,
  output logic                        print_valid,
  output logic [7:0]                  print_char,
  output logic [CYCLE_COUNT_BITS-1:0] elapsed_cycles
);
  pdp8_pkg::cmd_t  cmd;
  pdp8_pkg::stat_t stat;

  pdp8_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  pdp8_dp #(.MEMORY_WORDS(MEMORY_WORDS), .CYCLE_COUNT_BITS(CYCLE_COUNT_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .action(action), .load_address(load_address), .data_word(data_word),
    .keyboard_word(keyboard_word), .program_counter(program_counter),
    .accumulator_value(accumulator_value), .link_value(link_value), .halted(halted),
    .executed_word(executed_word), .keyboard_taken(keyboard_taken),
    .print_valid(print_valid), .print_char(print_char),
    .elapsed_cycles(elapsed_cycles)
  );

  // The halt flag is sticky until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(halted) && !$past(rst) |-> halted) else $error("halt flag cleared");

  // The cycle count never decreases.
  a_cyc_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> elapsed_cycles >= $past(elapsed_cycles))
    else $error("cycle count went down");

  // No request is taken while a result is offered.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken with result pending");

  // A result held under stall keeps its program counter.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(program_counter))
    else $error("result changed under stall");
endmodule
